>>> design/mip_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mip_pkg
// Widths, reset values and register indexes shared by the minimum image
// pair distance block.
// ---------------------------------------------------------------------------
package mip_pkg;

   // field widths
   localparam int IN_W   = 31;             // particle coordinate
   localparam int BOX_W  = 30;             // box length register
   localparam int D_W    = 31;             // folded separation
   localparam int DIST_W = 30;             // distance
   localparam int ROOT_W = 30;             // square root result bits
   localparam int RAD_W  = 2 * ROOT_W;     // radicand bits

   // stream word widths, padded to whole bytes
   localparam int REQ_W  = 128;
   localparam int RSP_W  = 96;
   localparam int RSP_PAD_W = RSP_W - 2 * D_W - DIST_W;

   localparam logic [BOX_W-1:0] BOX_RESET = 30'd655360;   // 10.0

   // register indexes
   localparam int CSR_IDX_W = 1;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BOX_X = 1'b0,
      CSR_BOX_Y = 1'b1
   } csr_idx_type;

endpackage
`default_nettype wire

>>> design/mip_fold.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mip_fold
// Pipelined fold of one separation into its nearest periodic image: a
// restoring divider, one dividend bit per stage, then a rounding stage.
// ---------------------------------------------------------------------------
module mip_fold #(
   parameter int MAG_W = 32
) (
   input  wire                       clock,
   input  wire                       en,
   input  wire  [MAG_W-1:0]          sep,
   input  wire  [mip_pkg::BOX_W-1:0] box_len,
   output logic [mip_pkg::D_W-1:0]   folded
);
   import mip_pkg::*;

   logic [BOX_W-1:0] len;
   logic [BOX_W-1:0] rem_ff [0:MAG_W];
   logic [MAG_W-1:0] sh_ff  [0:MAG_W];
   logic             neg_ff [0:MAG_W];
   logic [D_W-1:0]   folded_ff;
   logic [D_W-1:0]   folded_in;
   logic             round_up;
   logic [D_W-1:0]   res_mag;

   // zero length behaves as one lsb
   assign len = (box_len == '0) ? BOX_W'(1) : box_len;

   // load stage: magnitude and sign
   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff[0] <= sep[MAG_W-1];
         sh_ff[0]  <= sep[MAG_W-1] ? (~sep + MAG_W'(1)) : sep;
         rem_ff[0] <= '0;
      end
   end

   // divider stages, one dividend bit each
   for (genvar k = 1; k <= MAG_W; k++) begin : g_div
      logic [BOX_W:0] trial;
      logic           fits;
      assign trial = {rem_ff[k-1], sh_ff[k-1][MAG_W-1]};
      assign fits  = trial >= {1'b0, len};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= fits ? BOX_W'(trial - {1'b0, len}) : trial[BOX_W-1:0];
            sh_ff[k]  <= {sh_ff[k-1][MAG_W-2:0], 1'b0};
            neg_ff[k] <= neg_ff[k-1];
         end
      end
   end

   // round half away from zero: step one image further when 2r >= L
   always_comb begin
      round_up  = {rem_ff[MAG_W], 1'b0} >= {1'b0, len};
      res_mag   = {1'b0, rem_ff[MAG_W]} - (round_up ? {1'b0, len} : '0);
      folded_in = neg_ff[MAG_W] ? (~res_mag + D_W'(1)) : res_mag;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         folded_ff <= folded_in;
      end
   end

   assign folded = folded_ff;

endmodule
`default_nettype wire

>>> design/mip_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mip_isqrt
// Pipelined floor square root, one root bit per stage.
// ---------------------------------------------------------------------------
module mip_isqrt (
   input  wire                        clock,
   input  wire                        en,
   input  wire  [mip_pkg::RAD_W-1:0]  radicand,
   output logic [mip_pkg::ROOT_W-1:0] root
);
   import mip_pkg::*;

   logic [RAD_W-1:0]  rad_ff  [0:ROOT_W];
   logic [ROOT_W+1:0] rem_ff  [0:ROOT_W];
   logic [ROOT_W-1:0] root_ff [0:ROOT_W];

   // load stage
   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff[0]  <= radicand;
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
      end
   end

   // digit stages: bring down two radicand bits, try (4*root + 1)
   for (genvar k = 1; k <= ROOT_W; k++) begin : g_dig
      logic [ROOT_W+1:0] part;
      logic [ROOT_W+1:0] trial;
      logic              fits;
      assign part  = {rem_ff[k-1][ROOT_W-1:0], rad_ff[k-1][RAD_W-1 -: 2]};
      assign trial = {root_ff[k-1], 2'b01};
      assign fits  = part >= trial;
      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[k]  <= {rad_ff[k-1][RAD_W-3:0], 2'b00};
            rem_ff[k]  <= fits ? (part - trial) : part;
            root_ff[k] <= {root_ff[k-1][ROOT_W-2:0], fits};
         end
      end
   end

   assign root = root_ff[ROOT_W];

endmodule
`default_nettype wire

>>> design/min_image_pair_distance.sv
`timescale 1ns / 1ps
`default_nettype none
// Path from accepted request word to result word: one divider stage per separation bit,
// one root stage per result bit.
// Throughput: one word per cycle; the whole pipeline holds while a result waits.
// Reset (synchronous, active high) empties the pipeline and sets both box lengths to 10.0.
// ---------------------------------------------------------------------------
// min_image_pair_distance
// Minimum image separation and distance of particle pairs in a periodic box.
// ---------------------------------------------------------------------------
module min_image_pair_distance #(
   parameter int COORD_WIDTH = 32
) (
   input  wire                           clock,
   input  wire                           reset,
   // request: first_x, first_y, second_x, second_y (31 bits each), pad
   input  wire                           req_tvalid,
   output logic                          req_tready,
   input  wire  [mip_pkg::REQ_W-1:0]     req_tdata,
   // response: image_dx (31), image_dy (31), distance (30), pad
   output logic                          rsp_tvalid,
   input  wire                           rsp_tready,
   output logic [mip_pkg::RSP_W-1:0]     rsp_tdata,
   // register writes
   input  wire                           csr_we,
   input  wire  [mip_pkg::CSR_IDX_W-1:0] csr_idx,
   input  wire  [mip_pkg::BOX_W-1:0]     csr_wdata
);
   import mip_pkg::*;

   localparam int EXT_W  = (COORD_WIDTH > 32) ? COORD_WIDTH : 32;
   localparam int FOLD_L = COORD_WIDTH + 2;
   localparam int TAIL_L = ROOT_W + 2;          // square stage plus root pipe
   localparam int LAT    = 1 + FOLD_L + TAIL_L;

   logic [BOX_W-1:0]       box_x_ff, box_y_ff;
   logic [LAT-1:0]         vld_ff, vld_in;
   logic                   en;
   logic signed [IN_W-1:0] fx, fy, sx, sy;
   logic signed [EXT_W-1:0] diff_x, diff_y;
   logic [COORD_WIDTH-1:0] sep_x_ff, sep_y_ff;
   logic [D_W-1:0]         dx, dy;
   logic [BOX_W-1:0]       ax, ay;
   logic [RAD_W-1:0]       sq_x_ff, sq_y_ff;
   logic [RAD_W-1:0]       rad;
   logic [ROOT_W-1:0]      root;
   logic [D_W-1:0]         dx_dly_ff [0:TAIL_L-1];
   logic [D_W-1:0]         dy_dly_ff [0:TAIL_L-1];

   // whole pipeline moves unless the result word is stalled
   assign en         = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = en && !reset;
   assign rsp_tvalid = vld_ff[LAT-1];

   // box length registers
   always_ff @(posedge clock) begin
      if (reset) begin
         box_x_ff <= BOX_RESET;
         box_y_ff <= BOX_RESET;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_idx))
            CSR_BOX_X: box_x_ff <= csr_wdata;
            CSR_BOX_Y: box_y_ff <= csr_wdata;
            default:   ;
         endcase
      end
   end

   // valid bits travel with the words
   assign vld_in = {vld_ff[LAT-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // separation, wrapped to the coordinate register width
   assign fx = req_tdata[0*IN_W +: IN_W];
   assign fy = req_tdata[1*IN_W +: IN_W];
   assign sx = req_tdata[2*IN_W +: IN_W];
   assign sy = req_tdata[3*IN_W +: IN_W];
   assign diff_x = EXT_W'(fx) - EXT_W'(sx);
   assign diff_y = EXT_W'(fy) - EXT_W'(sy);

   always_ff @(posedge clock) begin
      if (en) begin
         sep_x_ff <= diff_x[COORD_WIDTH-1:0];
         sep_y_ff <= diff_y[COORD_WIDTH-1:0];
      end
   end

   mip_fold #(.MAG_W(COORD_WIDTH)) u_fold_x (
      .clock   (clock),
      .en      (en),
      .sep     (sep_x_ff),
      .box_len (box_x_ff),
      .folded  (dx)
   );

   mip_fold #(.MAG_W(COORD_WIDTH)) u_fold_y (
      .clock   (clock),
      .en      (en),
      .sep     (sep_y_ff),
      .box_len (box_y_ff),
      .folded  (dy)
   );

   // squares of the folded components
   assign ax = dx[D_W-1] ? BOX_W'(~dx + D_W'(1)) : dx[BOX_W-1:0];
   assign ay = dy[D_W-1] ? BOX_W'(~dy + D_W'(1)) : dy[BOX_W-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         sq_x_ff <= ax * ax;
         sq_y_ff <= ay * ay;
      end
   end

   assign rad = sq_x_ff + sq_y_ff;

   mip_isqrt u_isqrt (
      .clock    (clock),
      .en       (en),
      .radicand (rad),
      .root     (root)
   );

   // components wait alongside the root pipe
   always_ff @(posedge clock) begin
      if (en) begin
         dx_dly_ff[0] <= dx;
         dy_dly_ff[0] <= dy;
      end
   end

   for (genvar k = 1; k < TAIL_L; k++) begin : g_dly
      always_ff @(posedge clock) begin
         if (en) begin
            dx_dly_ff[k] <= dx_dly_ff[k-1];
            dy_dly_ff[k] <= dy_dly_ff[k-1];
         end
      end
   end

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, DIST_W'(root),
                       dy_dly_ff[TAIL_L-1], dx_dly_ff[TAIL_L-1]};

   // checks
   logic [D_W-1:0] chk_ax;
   assign chk_ax = rsp_tdata[D_W-1] ? (~rsp_tdata[D_W-1:0] + D_W'(1))
                                     : rsp_tdata[D_W-1:0];

`ifndef NO_ASSERTIONS
   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // the request side is open whenever the output is free
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request blocked with empty output");

   // folded x stays within half the box
   a_half_box: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && $stable(box_x_ff) && box_x_ff != '0 |->
         {1'b0, chk_ax} * 2 <= {2'b00, box_x_ff})
      else $error("image_dx outside half box");
`endif

endmodule
`default_nettype wire
